[hdl/crt_pkg.sv]
// Shared types and constants for the chunk residency table.
// Holds the transfer payload structs, command and outcome codes, and the controller link types.
// No dependencies; compile this file first.
package crt_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int LOC_W       = 32;
    localparam int RADIUS_W    = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 9;

    localparam logic [RADIUS_W-1:0] RADIUS_MIN   = 7'd1;
    localparam logic [RADIUS_W-1:0] RADIUS_MAX   = 7'd64;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 7'd8;
    localparam logic [CNT_W-1:0]    IN_USE_RESET = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0]    DEPTH_CNT    = CNT_W'(TABLE_DEPTH);

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_IN_USE = 1'd1;

    localparam logic [2:0] CMD_LOOKUP = 3'd0;
    localparam logic [2:0] CMD_LOAD   = 3'd1;
    localparam logic [2:0] CMD_UNLOAD = 3'd2;
    localparam logic [2:0] CMD_EVICT  = 3'd3;
    localparam logic [2:0] CMD_COUNT  = 3'd4;

    localparam logic [1:0] OUTCOME_OK          = 2'd0;
    localparam logic [1:0] OUTCOME_PRESENT     = 2'd1;
    localparam logic [1:0] OUTCOME_NOT_PRESENT = 2'd2;
    localparam logic [1:0] OUTCOME_FULL        = 2'd3;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_z;
    } crt_req_t;

    typedef struct packed {
        logic [1:0]       outcome;
        logic             hit;
        logic [IDX_W-1:0] entry_index;
        logic [CNT_W-1:0] tally;
    } crt_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } crt_state_t;

    typedef struct packed {
        logic load_item;
        logic issue;
        logic commit;
    } crt_ctl_t;

    typedef struct packed {
        logic issue_more;
        logic pipe_busy;
        logic out_free;
    } crt_stat_t;

endpackage

[hdl/crt_ctrl.sv]
// Controller state machine for the chunk residency table.
// Sequences accept, table scan and result commit; depends on crt_pkg.
module crt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  crt_pkg::crt_stat_t stat,
    output crt_pkg::crt_ctl_t  ctl
);
    import crt_pkg::*;

    crt_state_t state_reg;
    crt_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        req_ready     = 1'b0;
        ctl.load_item = 1'b0;
        ctl.issue     = 1'b0;
        ctl.commit    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.load_item = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ctl.issue = stat.issue_more;
                if (!stat.issue_more && !stat.pipe_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    ctl.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/crt_datapath.sv]
// Datapath for the chunk residency table: location memory, valid marks, scan and compare.
// Also holds the configuration registers and the result register; depends on crt_pkg.
module crt_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  crt_pkg::crt_req_t                req,
    output crt_pkg::crt_rsp_t                rsp,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    input  logic                             cfg_we,
    input  logic [crt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [crt_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  crt_pkg::crt_ctl_t                ctl,
    output crt_pkg::crt_stat_t               stat
);
    import crt_pkg::*;

    logic [LOC_W-1:0]       mem [TABLE_DEPTH];
    logic [LOC_W-1:0]       rd_data_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;

    logic [RADIUS_W-1:0] radius_reg;
    logic [CNT_W-1:0]    in_use_reg;

    crt_req_t         item_reg;
    logic [CNT_W-1:0] scan_reg;
    logic             cmp_vld_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             found_reg;
    logic [IDX_W-1:0] found_idx_reg;
    logic             free_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [CNT_W-1:0] tally_reg;

    crt_rsp_t rsp_reg;
    crt_rsp_t rsp_next;
    logic     rsp_valid_reg;

    logic [CNT_W-1:0]    n_eff;
    logic [RADIUS_W-1:0] r_eff;
    logic [LOC_W-1:0]    item_loc;
    logic                cur_valid;
    logic                cur_match;
    logic signed [16:0]  dx;
    logic signed [16:0]  dz;
    logic signed [16:0]  r_pos;
    logic signed [16:0]  r_neg;
    logic                far;
    logic                evict_now;
    logic                mem_we;
    logic [IDX_W-1:0]    wr_slot;
    logic                set_valid;
    logic                clr_found;

    always_comb
    begin
        n_eff = (in_use_reg > DEPTH_CNT) ? DEPTH_CNT : in_use_reg;
        if (radius_reg < RADIUS_MIN)
        begin
            r_eff = RADIUS_MIN;
        end
        else if (radius_reg > RADIUS_MAX)
        begin
            r_eff = RADIUS_MAX;
        end
        else
        begin
            r_eff = radius_reg;
        end
    end

    assign item_loc  = {item_reg.pos_z, item_reg.pos_x};
    assign cur_valid = valid_reg[cmp_idx_reg];
    assign cur_match = cur_valid && (rd_data_reg == item_loc);
    assign dx    = {item_reg.pos_x[15], item_reg.pos_x} - {rd_data_reg[15], rd_data_reg[15:0]};
    assign dz    = {item_reg.pos_z[15], item_reg.pos_z} - {rd_data_reg[31], rd_data_reg[31:16]};
    assign r_pos = {{(17 - RADIUS_W){1'b0}}, r_eff};
    assign r_neg = -r_pos;
    assign far   = (dx > r_pos) || (dx < r_neg) || (dz > r_pos) || (dz < r_neg);
    assign evict_now = cmp_vld_reg && cur_valid && far && (item_reg.command == CMD_EVICT);

    always_comb
    begin
        rsp_next  = '0;
        mem_we    = 1'b0;
        set_valid = 1'b0;
        clr_found = 1'b0;
        wr_slot   = free_reg ? free_idx_reg : '0;
        unique case (item_reg.command) inside
            CMD_LOOKUP, CMD_UNLOAD:
            begin
                if (found_reg)
                begin
                    rsp_next.outcome     = OUTCOME_OK;
                    rsp_next.hit         = 1'b1;
                    rsp_next.entry_index = found_idx_reg;
                    clr_found            = (item_reg.command == CMD_UNLOAD);
                end
                else
                begin
                    rsp_next.outcome = OUTCOME_NOT_PRESENT;
                end
            end
            CMD_LOAD:
            begin
                if (found_reg)
                begin
                    rsp_next.outcome     = OUTCOME_PRESENT;
                    rsp_next.entry_index = found_idx_reg;
                end
                else
                begin
                    rsp_next.outcome     = free_reg ? OUTCOME_OK : OUTCOME_FULL;
                    rsp_next.entry_index = wr_slot;
                    mem_we               = 1'b1;
                    set_valid            = 1'b1;
                end
            end
            CMD_EVICT, CMD_COUNT:
            begin
                rsp_next.tally = tally_reg;
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit && mem_we)
        begin
            mem[wr_slot] <= item_loc;
        end
        if (ctl.issue)
        begin
            rd_data_reg <= mem[scan_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (evict_now)
            begin
                valid_reg[cmp_idx_reg] <= 1'b0;
            end
            if (ctl.commit && set_valid)
            begin
                valid_reg[wr_slot] <= 1'b1;
            end
            if (ctl.commit && clr_found)
            begin
                valid_reg[found_idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            in_use_reg <= IN_USE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_WINDOW_RADIUS)
            begin
                radius_reg <= cfg_data[RADIUS_W-1:0];
            end
            if (cfg_index == REG_ENTRIES_IN_USE)
            begin
                in_use_reg <= cfg_data[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg    <= '0;
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            free_reg    <= 1'b0;
            tally_reg   <= '0;
        end
        else
        begin
            cmp_vld_reg <= ctl.issue;
            if (ctl.load_item)
            begin
                scan_reg  <= '0;
                found_reg <= 1'b0;
                free_reg  <= 1'b0;
                tally_reg <= '0;
            end
            else
            begin
                if (ctl.issue)
                begin
                    scan_reg <= scan_reg + CNT_W'(1);
                end
                if (cmp_vld_reg)
                begin
                    if (cur_match && !found_reg)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (!cur_valid && !free_reg)
                    begin
                        free_reg <= 1'b1;
                    end
                    if (evict_now || (cur_valid && item_reg.command == CMD_COUNT))
                    begin
                        tally_reg <= tally_reg + CNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            item_reg <= req;
        end
        if (ctl.issue)
        begin
            cmp_idx_reg <= scan_reg[IDX_W-1:0];
        end
        if (cmp_vld_reg && cur_match && !found_reg)
        begin
            found_idx_reg <= cmp_idx_reg;
        end
        if (cmp_vld_reg && !cur_valid && !free_reg)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
        if (ctl.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (ctl.commit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    assign stat.issue_more = (scan_reg < n_eff);
    assign stat.pipe_busy  = cmp_vld_reg;
    assign stat.out_free   = !rsp_valid_reg || rsp_ready;

endmodule

[hdl/chunk_residency_table.sv]
// Top level of the chunk residency table: joins the controller and the datapath.
// Depends on crt_pkg, crt_ctrl and crt_datapath.
//
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  crt_req_t (command, pos_x, pos_z)
// rsp       out        rsp_valid / rsp_ready  crt_rsp_t (outcome, hit, entry_index, tally)
// cfg       in         cfg_we                 cfg_index, cfg_data
//
// Each command scans min(entries_in_use, 256) entries of the location memory, one entry per
// cycle, and then returns to idle; a command with entries_in_use of 0 reads no entry.
// Reset clears all valid marks at once, so no clearing pass follows reset.
// A new command is accepted while the previous result still waits in the result register.
// A result held by a low rsp_ready stalls only the commit of the following command.
module chunk_residency_table (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  crt_pkg::crt_req_t                req,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output crt_pkg::crt_rsp_t                rsp,
    input  logic                             cfg_we,
    input  logic [crt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [crt_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import crt_pkg::*;

    crt_ctl_t  ctl;
    crt_stat_t stat;

    crt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    crt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .stat      (stat)
    );

`ifndef ASSERT_OFF
    a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |-> stat.out_free)
        else $error("Result committed while the result register was still occupied.");

    a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.issue |-> stat.issue_more)
        else $error("Table read issued beyond the entries in use.");

    a_load_when_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_item |-> (!stat.pipe_busy && !ctl.issue && !ctl.commit))
        else $error("New command accepted while a scan was still active.");

    a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |=> rsp_valid)
        else $error("Committed result did not appear on the response channel.");
`endif

endmodule
